>>> hw/rtl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// Touch slot allocator package
// Shared constants, codes and structures of the touch slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

   localparam int unsigned NUM_SLOTS  = 16;
   localparam int unsigned COORD_BITS = 12;
   localparam int unsigned SLOT_BITS  = $clog2(NUM_SLOTS);
   localparam int unsigned CNT_BITS   = $clog2(NUM_SLOTS + 1);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [CNT_BITS-1:0]   count_type;

   typedef enum logic [1:0] {
      OP_PRESS   = 2'd0,
      OP_MOVE    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_EXEC
   } state_type;

   typedef struct packed {
      op_type    op;
      slot_type  slot;
      coord_type pos_x;
      coord_type pos_y;
   } req_type;

   typedef struct packed {
      op_type     op_echo;
      slot_type   slot_out;
      coord_type  out_x;
      coord_type  out_y;
      logic       slot_active;
      status_type status;
      count_type  active_count;
      count_type  slots_used;
   } rsp_type;

   typedef struct packed {
      count_type high_water;
      slot_type  free_head;
      slot_type  free_tail;
      count_type free_count;
      count_type live_count;
   } counts_type;

   typedef struct packed {
      logic       coord_we;
      slot_type   coord_addr;
      coord_type  coord_x;
      coord_type  coord_y;
      logic       live_we;
      slot_type   live_addr;
      logic       live_value;
      logic       queue_we;
      slot_type   queue_data;
      counts_type counts;
   } update_type;

endpackage

`default_nettype wire

>>> hw/rtl/tsa_if.sv
// ----------------------------------------------------------------------------
// Touch slot allocator channels
// Valid/ready channels for touch events and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsa_req_if;
   import tsa_pkg::*;

   logic      valid;
   logic      ready;
   logic [1:0] op;
   slot_type  slot;
   coord_type pos_x;
   coord_type pos_y;

   modport source (output valid, output op, output slot, output pos_x, output pos_y,
                   input ready);
   modport sink   (input valid, input op, input slot, input pos_x, input pos_y,
                   output ready);
endinterface

interface tsa_rsp_if;
   import tsa_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] op_echo;
   slot_type   slot_out;
   coord_type  out_x;
   coord_type  out_y;
   logic       slot_active;
   logic [1:0] status;
   count_type  active_count;
   count_type  slots_used;

   modport source (output valid, output op_echo, output slot_out, output out_x,
                   output out_y, output slot_active, output status,
                   output active_count, output slots_used, input ready);
   modport sink   (input valid, input op_echo, input slot_out, input out_x,
                   input out_y, input slot_active, input status,
                   input active_count, input slots_used, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tsa_exec.sv
// ----------------------------------------------------------------------------
// Touch slot allocator event logic
// Decides one event from the latched beat and the memory read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_exec (
   input  tsa_pkg::req_type    req,
   input  tsa_pkg::counts_type counts,
   input  tsa_pkg::slot_type   queue_rd,
   input  tsa_pkg::coord_type  x_rd,
   input  tsa_pkg::coord_type  y_rd,
   input  logic                live_rd,
   output tsa_pkg::rsp_type    rsp,
   output tsa_pkg::update_type upd
);
   import tsa_pkg::*;

   logic     used;
   logic     got;
   slot_type sid;

   always_comb begin
      used = count_type'(req.slot) < counts.high_water;
      got  = 1'b0;
      sid  = req.slot;

      upd            = '0;
      upd.counts     = counts;
      upd.coord_x    = req.pos_x;
      upd.coord_y    = req.pos_y;
      upd.queue_data = req.slot;

      rsp             = '0;
      rsp.op_echo     = req.op;
      rsp.status      = STATUS_OK;

      case (req.op)
         OP_PRESS: begin
            if (counts.free_count != '0) begin
               sid = queue_rd;
               upd.counts.free_head = (counts.free_head == slot_type'(NUM_SLOTS - 1)) ?
                                      '0 : counts.free_head + 1'b1;
               upd.counts.free_count = counts.free_count - 1'b1;
               got = 1'b1;
            end else if (counts.high_water != count_type'(NUM_SLOTS)) begin
               sid = counts.high_water[SLOT_BITS-1:0];
               upd.counts.high_water = counts.high_water + 1'b1;
               got = 1'b1;
            end
            if (got) begin
               upd.coord_we   = 1'b1;
               upd.live_we    = 1'b1;
               upd.live_value = 1'b1;
               upd.counts.live_count = counts.live_count + 1'b1;
               rsp.out_x       = req.pos_x;
               rsp.out_y       = req.pos_y;
               rsp.slot_active = 1'b1;
            end else begin
               sid        = '0;
               rsp.status = STATUS_FULL;
            end
         end
         OP_MOVE: begin
            if (used && live_rd) begin
               upd.coord_we    = 1'b1;
               rsp.out_x       = req.pos_x;
               rsp.out_y       = req.pos_y;
               rsp.slot_active = 1'b1;
            end else begin
               rsp.status = STATUS_INVALID;
            end
         end
         OP_RELEASE: begin
            if (used && live_rd && counts.free_count != count_type'(NUM_SLOTS)) begin
               upd.live_we  = 1'b1;
               upd.queue_we = 1'b1;
               upd.counts.free_tail = (counts.free_tail == slot_type'(NUM_SLOTS - 1)) ?
                                      '0 : counts.free_tail + 1'b1;
               upd.counts.free_count = counts.free_count + 1'b1;
               if (counts.live_count != '0) begin
                  upd.counts.live_count = counts.live_count - 1'b1;
               end
            end else begin
               rsp.status = STATUS_INVALID;
            end
         end
         default: begin
            if (used) begin
               rsp.out_x       = x_rd;
               rsp.out_y       = y_rd;
               rsp.slot_active = live_rd;
               rsp.status      = live_rd ? STATUS_OK : STATUS_INVALID;
            end else begin
               rsp.status = STATUS_INVALID;
            end
         end
      endcase

      upd.coord_addr   = sid;
      upd.live_addr    = sid;
      rsp.slot_out     = sid;
      rsp.active_count = upd.counts.live_count;
      rsp.slots_used   = upd.counts.high_water;
   end

endmodule

`default_nettype wire

>>> hw/rtl/touch_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Touch slot allocator core
// Slot table with a FIFO free list; one result beat per touch event.
// An accepted event is latched with the coordinate and free-list reads; the
// execute state then does the read-modify-write and registers the result.
// No new event is taken in that state or while a result waits unread.
// Reset clears the counters, free-list pointers and slot live bits at once;
// the memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_slot_allocator_core (
   input  logic             clock,
   input  logic             reset,
   tsa_req_if.sink          req_ch,
   tsa_rsp_if.source        rsp_ch
);
   import tsa_pkg::*;

   state_type  state_ff, state_in;
   req_type    req_ff;
   counts_type counts_ff;
   logic [NUM_SLOTS-1:0] live_ff;
   rsp_type    rsp_ff, rsp_next;
   logic       rsp_valid_ff;
   update_type upd;
   logic       accept;
   logic       exec;

   logic [2*COORD_BITS-1:0] coord_mem [NUM_SLOTS];
   slot_type                queue_mem [NUM_SLOTS];
   logic [2*COORD_BITS-1:0] coord_rd_ff;
   slot_type                queue_rd_ff;

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      exec         = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
            if (req_ch.valid && req_ch.ready) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            exec     = 1'b1;
            state_in = STATE_IDLE;
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.op    <= op_type'(req_ch.op);
         req_ff.slot  <= req_ch.slot;
         req_ff.pos_x <= req_ch.pos_x;
         req_ff.pos_y <= req_ch.pos_y;
      end
   end

   always_ff @(posedge clock) begin
      if (exec && upd.coord_we) begin
         coord_mem[upd.coord_addr] <= {upd.coord_x, upd.coord_y};
      end
      if (accept) begin
         coord_rd_ff <= coord_mem[req_ch.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (exec && upd.queue_we) begin
         queue_mem[counts_ff.free_tail] <= upd.queue_data;
      end
      if (accept) begin
         queue_rd_ff <= queue_mem[counts_ff.free_head];
      end
   end

   tsa_exec u_exec (
      .req      (req_ff),
      .counts   (counts_ff),
      .queue_rd (queue_rd_ff),
      .x_rd     (coord_rd_ff[2*COORD_BITS-1:COORD_BITS]),
      .y_rd     (coord_rd_ff[COORD_BITS-1:0]),
      .live_rd  (live_ff[req_ff.slot]),
      .rsp      (rsp_next),
      .upd      (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff    <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec) begin
            counts_ff <= upd.counts;
            if (upd.live_we) begin
               live_ff[upd.live_addr] <= upd.live_value;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.op_echo      = rsp_ff.op_echo;
   assign rsp_ch.slot_out     = rsp_ff.slot_out;
   assign rsp_ch.out_x        = rsp_ff.out_x;
   assign rsp_ch.out_y        = rsp_ff.out_y;
   assign rsp_ch.slot_active  = rsp_ff.slot_active;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.active_count = rsp_ff.active_count;
   assign rsp_ch.slots_used   = rsp_ff.slots_used;

   // Every slot below the high-water mark is either live or waiting in the free list.
   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      counts_ff.free_count + counts_ff.live_count == counts_ff.high_water)
      else $error("free and live counts do not add up to the high-water mark");

   a_live_bits: assert property (@(posedge clock) disable iff (reset)
      $countones(live_ff) == int'(counts_ff.live_count))
      else $error("live count disagrees with the live bits");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_EXEC |-> !rsp_valid_ff || rsp_ch.ready)
      else $error("result register still occupied when a result is produced");

   a_press_goes_live: assert property (@(posedge clock) disable iff (reset)
      exec && req_ff.op == OP_PRESS && rsp_next.status == STATUS_OK
      |=> live_ff[$past(rsp_next.slot_out)])
      else $error("pressed slot did not become live");

endmodule

`default_nettype wire
